FILE: sv/mrf_pkg.sv
// shared types, constants and the crc byte update for the modbus rtu request framer
// no dependencies
package mrf_pkg;

  // request operations
  localparam logic [1:0] OP_READ_COILS   = 2'd0;
  localparam logic [1:0] OP_READ_HOLDING = 2'd1;
  localparam logic [1:0] OP_WRITE_COIL   = 2'd2;
  localparam logic [1:0] OP_WRITE_REG    = 2'd3;

  // modbus function codes
  localparam logic [7:0] FC_READ_COILS   = 8'h01;
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_COIL   = 8'h05;
  localparam logic [7:0] FC_WRITE_REG    = 8'h06;

  localparam logic [15:0] COIL_ON       = 16'hFF00;
  localparam logic [15:0] COIL_OFF      = 16'h0000;
  localparam logic [15:0] HOLDING_COUNT = 16'h0001;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned BODY_LEN  = 6;
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(BODY_LEN);
  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  slave_address;
    logic [15:0] item_address;
    logic [15:0] item_value;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } rsp_t;

  // frame body in transmit order, entry 0 goes first
  typedef logic [BODY_LEN-1:0][7:0] body_t;

  // one byte through the reflected crc-16/modbus shift register
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

FILE: sv/mrf_frame_builder.sv
// maps one request onto the six body bytes of the rtu frame
// depends on mrf_pkg
module mrf_frame_builder import mrf_pkg::*; (
  input  req_t  req_i,
  output body_t body_o
);

  logic [7:0]  func_code;
  logic [15:0] word;

  always_comb begin
    case (req_i.operation)
      OP_READ_COILS: begin
        func_code = FC_READ_COILS;
        word      = req_i.item_value;
      end
      OP_READ_HOLDING: begin
        func_code = FC_READ_HOLDING;
        word      = HOLDING_COUNT;
      end
      OP_WRITE_COIL: begin
        func_code = FC_WRITE_COIL;
        word      = (req_i.item_value != 16'h0000) ? COIL_ON : COIL_OFF;
      end
      default: begin
        func_code = FC_WRITE_REG;
        word      = req_i.item_value;
      end
    endcase
  end

  assign body_o[0] = req_i.slave_address;
  assign body_o[1] = func_code;
  assign body_o[2] = req_i.item_address[15:8];
  assign body_o[3] = req_i.item_address[7:0];
  assign body_o[4] = word[15:8];
  assign body_o[5] = word[7:0];

endmodule

FILE: sv/modbus_rtu_request_framer_top.sv
// modbus rtu request framer: one request in, eight frame bytes out
// bytes pass body_q then the output register, one byte per cycle while out_stall_i is low
// frame bytes leave one at a time through the single-byte output register
// the next request is taken in the cycle the last byte of the current one is loaded
// crc runs one byte per cycle alongside the output unless it stalls, so the crc bytes are ready on time
// reset (rst_ni low, asynchronous) empties the sequencer and the output register
module modbus_rtu_request_framer_top import mrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  // request held while its bytes go out
  body_t            body_q;
  logic [15:0]      crc_q;
  logic [IDX_W-1:0] idx_q;
  logic             busy_q;

  // output register
  logic             ovalid_q;
  rsp_t             odata_q;

  body_t            body_d;
  logic [7:0]       byte_sel;
  logic             load_out;
  logic             is_last;
  logic             in_accept;

  mrf_frame_builder u_builder (
    .req_i  (in_data_i),
    .body_o (body_d)
  );

  // output register can take a byte when empty or being drained
  assign load_out  = busy_q && (!ovalid_q || !out_stall_i);
  assign is_last   = (idx_q == IDX_CRC_HI);
  // a new request can enter as soon as the last byte moves into the output register
  assign in_stall_o = busy_q && !(load_out && is_last);
  assign in_accept  = in_valid_i && !in_stall_o;

  // byte select: body bytes first, then crc low and high
  always_comb begin
    unique case (idx_q)
      IDX_CRC_LO: byte_sel = crc_q[7:0];
      IDX_CRC_HI: byte_sel = crc_q[15:8];
      default:    byte_sel = body_q[idx_q];
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      // a new request overrides the finishing one in the same cycle
      if (in_accept) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (load_out) begin
        idx_q <= idx_q + 1'b1;
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      odata_q.frame_byte <= byte_sel;
      odata_q.last_byte  <= is_last;
    end
    if (in_accept) begin
      body_q <= body_d;
      crc_q  <= CRC_INIT;
    end else if (load_out && (idx_q < IDX_CRC_LO)) begin
      // crc absorbs each body byte as it leaves
      crc_q <= crc16_byte(crc_q, byte_sel);
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

FILE: tb/tb_modbus_rtu_request_framer_top.sv
// self-checking testbench for modbus_rtu_request_framer_top: directed and random requests,
// each checked byte by byte against a frame built here, crc included
// depends on mrf_pkg and modbus_rtu_request_framer_top
module tb_modbus_rtu_request_framer_top;
  import mrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one request waiting to be sent, with the idling that goes with its phase
  typedef struct {
    req_t        req;
    int unsigned gap_pct;   // chance in a hundred that the sender idles a cycle
    int unsigned hold_pct;  // chance in a hundred that the receiver stalls a cycle
  } pending_req_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_data_o;

  pending_req_t request_q[$];     // requests not yet offered
  rsp_t         frame_byte_q[$];  // bytes still owed by the block, oldest first
  int unsigned  tx_gap_pct  = 0;
  int unsigned  rx_hold_pct = 0;
  int unsigned  mismatch_count = 0;

  modbus_rtu_request_framer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // crc-16/modbus over the six body bytes, taken bit by bit, lsb of each byte first
  function automatic logic [15:0] modbus_crc_of_body(input logic [7:0] body [6]);
    logic [15:0] crc;
    logic        fb;
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      for (int b = 0; b < 8; b++) begin
        fb  = crc[0] ^ body[i][b];
        crc = {1'b0, crc[15:1]};
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
    end
    return crc;
  endfunction

  // queue the eight bytes that the block must send for one request
  task automatic queue_frame_bytes(input req_t r);
    logic [7:0]  body [6];
    logic [7:0]  fcode;
    logic [15:0] word;
    logic [15:0] crc;
    rsp_t        b;
    case (r.operation)
      OP_READ_COILS: begin
        fcode = FC_READ_COILS;
        word  = r.item_value;  // coil count goes out as given, zero and oversize too
      end
      OP_READ_HOLDING: begin
        fcode = FC_READ_HOLDING;
        word  = 16'h0001;      // always one register, value ignored
      end
      OP_WRITE_COIL: begin
        fcode = FC_WRITE_COIL;
        word  = (r.item_value != 16'h0000) ? 16'hFF00 : 16'h0000;
      end
      default: begin
        fcode = FC_WRITE_REG;
        word  = r.item_value;
      end
    endcase
    body[0] = r.slave_address;
    body[1] = fcode;
    body[2] = r.item_address[15:8];
    body[3] = r.item_address[7:0];
    body[4] = word[15:8];
    body[5] = word[7:0];
    crc = modbus_crc_of_body(body);
    for (int k = 0; k < 6; k++) begin
      b.frame_byte = body[k];
      b.last_byte  = 1'b0;
      frame_byte_q = {frame_byte_q, b};
    end
    // crc goes low byte first, the high byte closes the frame
    b.frame_byte = crc[7:0];
    b.last_byte  = 1'b0;
    frame_byte_q = {frame_byte_q, b};
    b.frame_byte = crc[15:8];
    b.last_byte  = 1'b1;
    frame_byte_q = {frame_byte_q, b};
  endtask

  task automatic add_request(input logic [1:0] op, input logic [7:0] slave,
                             input logic [15:0] addr, input logic [15:0] value,
                             input int unsigned gap, input int unsigned hold);
    pending_req_t p;
    p.req.operation     = op;
    p.req.slave_address = slave;
    p.req.item_address  = addr;
    p.req.item_value    = value;
    p.gap_pct  = gap;
    p.hold_pct = hold;
    request_q = {request_q, p};
  endtask

  // driver: offers requests, holds a stalled one steady, predicts on each transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        queue_frame_bytes(in_data_i);
      end
      if (in_valid_i && in_stall_o) begin
        // stalled: keep valid and payload as they are
      end else if (request_q.size() != 0 &&
                   $urandom_range(0, 99) >= request_q[0].gap_pct) begin
        in_valid_i  <= 1'b1;
        in_data_i   <= request_q[0].req;
        tx_gap_pct  <= request_q[0].gap_pct;
        rx_hold_pct <= request_q[0].hold_pct;
        void'(request_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: random stall on the output, every byte transaction checked against the oldest
  // owed byte
  always @(posedge clk_i) begin
    rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (frame_byte_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: byte with nothing owed: expected none, actual byte %h last %b",
                   $time, out_data_o.frame_byte, out_data_o.last_byte);
        end else begin
          want = frame_byte_q.pop_front();
          if (out_data_o.frame_byte !== want.frame_byte) begin
            mismatch_count++;
            $display("%0t: frame_byte: expected %h, actual %h",
                     $time, want.frame_byte, out_data_o.frame_byte);
          end
          if (out_data_o.last_byte !== want.last_byte) begin
            mismatch_count++;
            $display("%0t: last_byte: expected %b, actual %b",
                     $time, want.last_byte, out_data_o.last_byte);
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < rx_hold_pct);
    end
  end

  // stimulus and end of run
  initial begin
    logic [1:0]  op;
    logic [15:0] value;
    int unsigned gap;
    int unsigned hold;

    // directed part, no idling: field extremes, every operation, each special case
    add_request(OP_READ_COILS,   8'h00, 16'h0000, 16'h0000, 0, 0);  // zero coil count
    add_request(OP_READ_COILS,   8'hFF, 16'hFFFF, 16'hFFFF, 0, 0);
    add_request(OP_READ_COILS,   8'h11, 16'h0013, 16'h07D1, 0, 0);  // above the modbus limit
    add_request(OP_READ_COILS,   8'h01, 16'h0000, 16'h0001, 0, 0);
    add_request(OP_READ_HOLDING, 8'h00, 16'h0000, 16'h0000, 0, 0);
    add_request(OP_READ_HOLDING, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 0);  // value ignored
    add_request(OP_READ_HOLDING, 8'h01, 16'h006B, 16'h5A5A, 0, 0);
    add_request(OP_WRITE_COIL,   8'h00, 16'h0000, 16'h0000, 0, 0);  // coil off
    add_request(OP_WRITE_COIL,   8'hFF, 16'hFFFF, 16'hFFFF, 0, 0);  // coil on
    add_request(OP_WRITE_COIL,   8'h11, 16'h00AC, 16'h0001, 0, 0);  // smallest nonzero is on
    add_request(OP_WRITE_COIL,   8'h11, 16'h00AC, 16'h8000, 0, 0);
    add_request(OP_WRITE_COIL,   8'h11, 16'h00AC, 16'h00FF, 0, 0);
    add_request(OP_WRITE_REG,    8'h00, 16'h0000, 16'h0000, 0, 0);
    add_request(OP_WRITE_REG,    8'hFF, 16'hFFFF, 16'hFFFF, 0, 0);
    add_request(OP_WRITE_REG,    8'h11, 16'h0001, 16'h0003, 0, 0);
    add_request(OP_WRITE_REG,    8'hAA, 16'h5555, 16'hAAAA, 0, 0);
    add_request(OP_WRITE_REG,    8'h55, 16'hAAAA, 16'h5555, 0, 0);

    // random part in four idling phases: none, sender idle, receiver stall, both light
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap = 0;  hold = 0;  end
        1:       begin gap = 59; hold = 0;  end
        2:       begin gap = 0;  hold = 59; end
        default: begin gap = 14; hold = 14; end
      endcase
      for (int n = 0; n < 65; n++) begin
        op    = 2'($urandom_range(0, 3));
        value = 16'($urandom);
        // zero values are worth hitting often: coil off, zero count
        if ($urandom_range(0, 7) == 0) begin
          value = 16'h0000;
        end
        add_request(op, 8'($urandom), 16'($urandom), value, gap, hold);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every request sent, then every owed byte received, then a short drain
    while (request_q.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (frame_byte_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("modbus_rtu_request_framer_top: match");
    end else begin
      $display("modbus_rtu_request_framer_top: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("modbus_rtu_request_framer_top: mismatch");
    $finish;
  end

endmodule
